// ===== hdl/csbo_pkg.sv =====
// Package for the collinear segment best overlap block.
// Holds widths, register indexes, the sequencer states and the payload structs.
// No dependencies.
package csbo_pkg;

   localparam int COORD_WIDTH     = 24;
   localparam int INDEX_WIDTH     = 16;
   localparam int CFG_WIDTH       = 16;
   localparam int OVERLAP_WIDTH   = 25;
   localparam int CSR_INDEX_WIDTH = 2;

   // Derived widths of the datapath.
   localparam int DIFF_WIDTH = COORD_WIDTH + 1;
   localparam int LEN_WIDTH  = COORD_WIDTH + 1;
   localparam int MUL_WIDTH  = (COORD_WIDTH + 2 > CFG_WIDTH + 1) ? COORD_WIDTH + 2
                                                                 : CFG_WIDTH + 1;
   localparam int PROD_WIDTH = 2 * MUL_WIDTH;
   localparam int RAD_WIDTH  = 2 * LEN_WIDTH;
   localparam int REM_WIDTH  = LEN_WIDTH + 3;
   localparam int CNT_WIDTH  = $clog2(LEN_WIDTH);
   localparam int SAT_WIDTH  = (LEN_WIDTH > OVERLAP_WIDTH) ? LEN_WIDTH : OVERLAP_WIDTH;

   localparam logic [CFG_WIDTH-1:0]     CFG_RESET   = CFG_WIDTH'(128);
   localparam logic [OVERLAP_WIDTH-1:0] OVERLAP_MAX = '1;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TOLERANCE   = CSR_INDEX_WIDTH'(0);
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MIN_OVERLAP = CSR_INDEX_WIDTH'(1);

   localparam logic CMD_QUERY = 1'b0;
   localparam logic CMD_LINE  = 1'b1;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DXX,
      S_DYY,
      S_SUM,
      S_SQRT,
      S_LIM,
      S_LL,
      S_LLS,
      S_CR1,
      S_CR2,
      S_DT1,
      S_DT2,
      S_DT3,
      S_PROJ,
      S_DIV,
      S_UPD
   } state_type;

   typedef struct packed {
      logic                          command;
      logic signed [COORD_WIDTH-1:0] point_a_x;
      logic signed [COORD_WIDTH-1:0] point_a_y;
      logic signed [COORD_WIDTH-1:0] point_b_x;
      logic signed [COORD_WIDTH-1:0] point_b_y;
      logic [INDEX_WIDTH-1:0]        line_index;
      logic                          last_item;
   } req_type;

   typedef struct packed {
      logic                     found;
      logic [INDEX_WIDTH-1:0]   best_index;
      logic [OVERLAP_WIDTH-1:0] best_overlap;
   } rsp_type;

endpackage

// ===== hdl/collinear_segment_best_overlap.sv =====
// Items are taken one at a time. The work on a candidate is set by the bit-serial square root
// and the two bit-serial divisions on the shared remainder unit.
// A projection clamped to 0 or to the length skips its division, and a dropped candidate
// stops early. A result waiting for its register holds the block in its final step.
// Synchronous active-high reset: tolerance and minimum overlap go to 128, the stored
// query and the running best go to zero.
module collinear_segment_best_overlap
   import csbo_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  req_type                    req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output rsp_type                    rsp_data,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CFG_WIDTH-1:0]       csr_data
);

   state_type state_ff, state_in;
   logic [CFG_WIDTH-1:0] tol_ff, tol_in, min_ff, min_in;
   logic signed [COORD_WIDTH-1:0] qfx_ff, qfx_in, qfy_ff, qfy_in;
   logic signed [COORD_WIDTH-1:0] qtx_ff, qtx_in, qty_ff, qty_in;
   logic signed [COORD_WIDTH-1:0] ax_ff, ax_in, ay_ff, ay_in;
   logic signed [DIFF_WIDTH-1:0]  dx_ff, dx_in, dy_ff, dy_in;
   logic [INDEX_WIDTH-1:0] idx_ff, idx_in;
   logic last_ff, last_in;
   logic [LEN_WIDTH-1:0] len_ff, len_in, t0_ff, t0_in, t1_ff, t1_in, root_ff, root_in;
   logic signed [PROD_WIDTH-1:0] prod_ff, prod_in, acc_ff, acc_in, lim_ff, lim_in;
   logic signed [PROD_WIDTH-1:0] ll_ff, ll_in;
   logic [RAD_WIDTH-1:0] rad_ff, rad_in;
   logic [REM_WIDTH-1:0] rem_ff, rem_in;
   logic [CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic pt_ff, pt_in;
   logic [INDEX_WIDTH-1:0] best_idx_ff, best_idx_in;
   logic [OVERLAP_WIDTH-1:0] best_ov_ff, best_ov_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   logic signed [COORD_WIDTH-1:0] px, py;
   logic signed [DIFF_WIDTH-1:0]  qx, qy;
   logic signed [MUL_WIDTH-1:0]   mul_a, mul_b;
   logic signed [PROD_WIDTH-1:0]  acc_abs, sum_s;
   logic [REM_WIDTH-1:0]          rem_sh, trial;
   logic [LEN_WIDTH:0]            div_r;
   logic [LEN_WIDTH-1:0]          t_val, diff_t;
   logic                          t_ready, finish, last_step;
   logic [SAT_WIDTH-1:0]          ov_ext;
   logic [OVERLAP_WIDTH-1:0]      ov_sat;

   function automatic logic found_next(input logic [OVERLAP_WIDTH-1:0] ov,
                                       input logic [CFG_WIDTH-1:0] lo);
      return (ov != '0) && (ov >= OVERLAP_WIDTH'(lo));
   endfunction

   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Query point relative to the candidate start.
   assign px = pt_ff ? qtx_ff : qfx_ff;
   assign py = pt_ff ? qty_ff : qfy_ff;
   assign qx = DIFF_WIDTH'(px) - DIFF_WIDTH'(ax_ff);
   assign qy = DIFF_WIDTH'(py) - DIFF_WIDTH'(ay_ff);

   // Operand selection for the shared multiplier.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_DXX: begin
            mul_a = MUL_WIDTH'(dx_ff);
            mul_b = MUL_WIDTH'(dx_ff);
         end
         S_DYY: begin
            mul_a = MUL_WIDTH'(dy_ff);
            mul_b = MUL_WIDTH'(dy_ff);
         end
         S_LIM: begin
            mul_a = MUL_WIDTH'($signed({1'b0, tol_ff}));
            mul_b = MUL_WIDTH'($signed({1'b0, len_ff}));
         end
         S_LL: begin
            mul_a = MUL_WIDTH'($signed({1'b0, len_ff}));
            mul_b = MUL_WIDTH'($signed({1'b0, len_ff}));
         end
         S_CR1: begin
            mul_a = MUL_WIDTH'(dx_ff);
            mul_b = MUL_WIDTH'(qy);
         end
         S_CR2: begin
            mul_a = MUL_WIDTH'(dy_ff);
            mul_b = MUL_WIDTH'(qx);
         end
         S_DT1: begin
            mul_a = MUL_WIDTH'(dx_ff);
            mul_b = MUL_WIDTH'(qx);
         end
         S_DT2: begin
            mul_a = MUL_WIDTH'(dy_ff);
            mul_b = MUL_WIDTH'(qy);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign acc_abs   = acc_ff[PROD_WIDTH-1] ? -acc_ff : acc_ff;
   assign sum_s     = acc_ff + prod_ff;
   assign last_step = (cnt_ff == CNT_WIDTH'(LEN_WIDTH - 1));

   // Shared remainder unit: one square-root digit or one quotient bit a cycle.
   assign rem_sh = {rem_ff[REM_WIDTH-3:0], rad_ff[RAD_WIDTH-1 -: 2]};
   assign trial  = REM_WIDTH'({root_ff, 2'b01});
   assign div_r  = {rem_ff[LEN_WIDTH-1:0], rad_ff[RAD_WIDTH-1]};

   assign diff_t = (t0_ff > t1_ff) ? t0_ff - t1_ff : t1_ff - t0_ff;
   assign ov_ext = SAT_WIDTH'(diff_t);
   assign ov_sat = (ov_ext > SAT_WIDTH'(OVERLAP_MAX)) ? OVERLAP_MAX
                                                      : OVERLAP_WIDTH'(ov_ext);

   always_comb begin
      state_in     = state_ff;
      tol_in       = tol_ff;
      min_in       = min_ff;
      qfx_in       = qfx_ff;
      qfy_in       = qfy_ff;
      qtx_in       = qtx_ff;
      qty_in       = qty_ff;
      ax_in        = ax_ff;
      ay_in        = ay_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      idx_in       = idx_ff;
      last_in      = last_ff;
      len_in       = len_ff;
      t0_in        = t0_ff;
      t1_in        = t1_ff;
      root_in      = root_ff;
      prod_in      = mul_a * mul_b;
      acc_in       = acc_ff;
      lim_in       = lim_ff;
      ll_in        = ll_ff;
      rad_in       = rad_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      pt_in        = pt_ff;
      best_idx_in  = best_idx_ff;
      best_ov_in   = best_ov_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      t_val        = '0;
      t_ready      = 1'b0;
      finish       = 1'b0;

      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_TOLERANCE:   tol_in = csr_data;
            CSR_MIN_OVERLAP: min_in = csr_data;
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid && !req_stall) begin
               last_in = req_data.last_item;
               if (req_data.command == CMD_QUERY) begin
                  qfx_in     = req_data.point_a_x;
                  qfy_in     = req_data.point_a_y;
                  qtx_in     = req_data.point_b_x;
                  qty_in     = req_data.point_b_y;
                  best_idx_in = '0;
                  best_ov_in  = '0;
                  if (req_data.last_item) begin
                     state_in = S_UPD;
                     pt_in    = 1'b0;
                  end
               end else begin
                  ax_in  = req_data.point_a_x;
                  ay_in  = req_data.point_a_y;
                  dx_in  = DIFF_WIDTH'(req_data.point_b_x) - DIFF_WIDTH'(req_data.point_a_x);
                  dy_in  = DIFF_WIDTH'(req_data.point_b_y) - DIFF_WIDTH'(req_data.point_a_y);
                  idx_in = req_data.line_index;
                  pt_in  = 1'b0;
                  if (req_data.point_a_x == req_data.point_b_x &&
                      req_data.point_a_y == req_data.point_b_y) begin
                     // Zero-length line: nothing to match, only the end of the list matters.
                     if (req_data.last_item) begin
                        state_in = S_UPD;
                     end
                     t0_in = '0;
                     t1_in = '0;
                  end else begin
                     state_in = S_DXX;
                  end
               end
            end
         end
         S_DXX: state_in = S_DYY;
         S_DYY: begin
            acc_in   = prod_ff;
            state_in = S_SUM;
         end
         S_SUM: begin
            rad_in   = RAD_WIDTH'(sum_s);
            rem_in   = '0;
            root_in  = '0;
            cnt_in   = '0;
            state_in = S_SQRT;
         end
         S_SQRT: begin
            rad_in = rad_ff << 2;
            cnt_in = cnt_ff + CNT_WIDTH'(1);
            if (rem_sh >= trial) begin
               rem_in  = rem_sh - trial;
               root_in = {root_ff[LEN_WIDTH-2:0], 1'b1};
            end else begin
               rem_in  = rem_sh;
               root_in = {root_ff[LEN_WIDTH-2:0], 1'b0};
            end
            if (last_step) begin
               len_in   = root_in;
               state_in = S_LIM;
            end
         end
         S_LIM: state_in = S_LL;
         S_LL: begin
            lim_in   = prod_ff;
            state_in = S_LLS;
         end
         S_LLS: begin
            ll_in    = prod_ff;
            state_in = S_CR1;
         end
         S_CR1: state_in = S_CR2;
         S_CR2: begin
            acc_in   = prod_ff;
            state_in = S_DT1;
         end
         S_DT1: begin
            acc_in   = acc_ff - prod_ff;
            state_in = S_DT2;
         end
         S_DT2: begin
            if (acc_abs > lim_ff) begin
               // Query endpoint too far from the line: the candidate is dropped.
               finish = 1'b1;
            end else begin
               acc_in   = prod_ff;
               state_in = S_DT3;
            end
         end
         S_DT3: begin
            acc_in   = sum_s;
            state_in = S_PROJ;
         end
         S_PROJ: begin
            if (acc_ff[PROD_WIDTH-1]) begin
               t_val   = '0;
               t_ready = 1'b1;
            end else if (acc_ff >= ll_ff) begin
               t_val   = len_ff;
               t_ready = 1'b1;
            end else begin
               // The quotient is below len, so the upper half already sits below it.
               rem_in   = REM_WIDTH'(acc_ff[RAD_WIDTH-1:LEN_WIDTH]);
               rad_in   = {acc_ff[LEN_WIDTH-1:0], LEN_WIDTH'(0)};
               root_in  = '0;
               cnt_in   = '0;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            rad_in = rad_ff << 1;
            cnt_in = cnt_ff + CNT_WIDTH'(1);
            if (div_r >= {1'b0, len_ff}) begin
               rem_in  = REM_WIDTH'(div_r - {1'b0, len_ff});
               root_in = {root_ff[LEN_WIDTH-2:0], 1'b1};
            end else begin
               rem_in  = REM_WIDTH'(div_r);
               root_in = {root_ff[LEN_WIDTH-2:0], 1'b0};
            end
            if (last_step) begin
               t_val   = root_in;
               t_ready = 1'b1;
            end
         end
         S_UPD: begin
            // Reached after both projections, or directly at the end of a list.
            if (pt_ff && ov_sat > best_ov_ff) begin
               best_ov_in  = ov_sat;
               best_idx_in = idx_ff;
            end
            pt_in  = 1'b0;
            finish = 1'b1;
         end
         default: state_in = S_IDLE;
      endcase

      if (t_ready) begin
         if (!pt_ff) begin
            t0_in    = t_val;
            pt_in    = 1'b1;
            state_in = S_CR1;
         end else begin
            t1_in    = t_val;
            state_in = S_UPD;
         end
      end

      if (finish) begin
         if (!last_ff) begin
            state_in = S_IDLE;
         end else if (!rsp_valid_ff || !rsp_stall) begin
            // The running best including this candidate, then cleared for the next list.
            rsp_valid_in             = 1'b1;
            rsp_data_in.found        = found_next(best_ov_in, min_ff);
            rsp_data_in.best_index   = found_next(best_ov_in, min_ff) ? best_idx_in : '0;
            rsp_data_in.best_overlap = found_next(best_ov_in, min_ff) ? best_ov_in : '0;
            best_idx_in              = '0;
            best_ov_in               = '0;
            state_in                 = S_IDLE;
         end else begin
            // Result register busy: hold here with the candidate already folded in.
            pt_in    = 1'b0;
            state_in = S_UPD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         tol_ff       <= CFG_RESET;
         min_ff       <= CFG_RESET;
         qfx_ff       <= '0;
         qfy_ff       <= '0;
         qtx_ff       <= '0;
         qty_ff       <= '0;
         best_idx_ff  <= '0;
         best_ov_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         last_ff      <= 1'b0;
         pt_ff        <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         tol_ff       <= tol_in;
         min_ff       <= min_in;
         qfx_ff       <= qfx_in;
         qfy_ff       <= qfy_in;
         qtx_ff       <= qtx_in;
         qty_ff       <= qty_in;
         best_idx_ff  <= best_idx_in;
         best_ov_ff   <= best_ov_in;
         rsp_valid_ff <= rsp_valid_in;
         last_ff      <= last_in;
         pt_ff        <= pt_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      ax_ff       <= ax_in;
      ay_ff       <= ay_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      idx_ff      <= idx_in;
      len_ff      <= len_in;
      t0_ff       <= t0_in;
      t1_ff       <= t1_in;
      root_ff     <= root_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      lim_ff      <= lim_in;
      ll_ff       <= ll_in;
      rad_ff      <= rad_in;
      rem_ff      <= rem_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
